// ----- src/pdpt_pkg.sv -----
`default_nettype none

package pdpt_pkg;

  localparam int unsigned ColorW = 6;
  localparam int unsigned LevelW = 4;
  localparam int unsigned ProdW = 10;
  localparam int unsigned RecipW = 10;
  localparam int unsigned StepW = 3;

  localparam logic [ColorW-1:0] ColorMax = 6'd63;
  localparam logic [LevelW-1:0] PainDiv = 4'd10;
  localparam logic [LevelW-1:0] PossDiv = 4'd12;
  localparam logic [LevelW-1:0] PainTop = 4'd10;
  localparam logic [LevelW-1:0] PossTop = 4'd13;

  // floor(x / 10) = (x * 205) >> 11 and floor(x / 12) = (x * 683) >> 13 for x < 1024
  localparam logic [RecipW-1:0] PainRecip = 10'd205;
  localparam int unsigned PainShift = 11;
  localparam logic [RecipW-1:0] PossRecip = 10'd683;
  localparam int unsigned PossShift = 13;

  localparam logic [StepW-1:0] StepPainRed = 3'd0;
  localparam logic [StepW-1:0] StepPainGreen = 3'd1;
  localparam logic [StepW-1:0] StepPainBlue = 3'd2;
  localparam logic [StepW-1:0] StepPossRed = 3'd3;
  localparam logic [StepW-1:0] StepPossGreen = 3'd4;
  localparam logic [StepW-1:0] StepPossBlue = 3'd5;

  typedef enum logic [1:0] {
    ACT_TINT = 2'd0,
    ACT_FRAME = 2'd1,
    ACT_PAIN = 2'd2,
    ACT_SET_POSS = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    MODE_FREEZE = 2'd0,
    MODE_RAMP_UP = 2'd1,
    MODE_RAMP_DOWN = 2'd2,
    MODE_SPARE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic toward;
    logic div12;
  } scale_op_t;

endpackage

`default_nettype wire

// ----- src/pdpt_scale.sv -----
`default_nettype none

module pdpt_scale (
  input  wire logic                       clk_i,
  input  wire logic                       issue_i,
  input  wire logic [pdpt_pkg::ColorW-1:0] c_i,
  input  wire logic [pdpt_pkg::LevelW-1:0] lvl_i,
  input  wire pdpt_pkg::scale_op_t        op_i,
  output logic      [pdpt_pkg::ColorW-1:0] res_o
);
  import pdpt_pkg::*;

  logic [ColorW-1:0]        x_d;
  logic [LevelW-1:0]        div_d;
  logic [LevelW-1:0]        fac_d;
  logic [ProdW-1:0]         prod_d;
  logic [ProdW-1:0]         prod_q;
  logic [ColorW-1:0]        c_q;
  scale_op_t                op_q;
  logic [RecipW-1:0]        recip;
  logic [ProdW+RecipW-1:0]  full;
  logic [ColorW-1:0]        quot;

  always_comb begin
    x_d    = op_i.toward ? ColorMax - c_i : c_i;
    div_d  = op_i.div12 ? PossDiv : PainDiv;
    fac_d  = op_i.toward ? lvl_i : div_d - lvl_i;
    prod_d = ProdW'(x_d) * ProdW'(fac_d);
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      prod_q <= prod_d;
      c_q    <= c_i;
      op_q   <= op_i;
    end
  end

  always_comb begin
    recip = op_q.div12 ? PossRecip : PainRecip;
    full  = (ProdW+RecipW)'(prod_q) * (ProdW+RecipW)'(recip);
    if (op_q.div12) begin
      quot = ColorW'(full >> PossShift);
    end else begin
      quot = ColorW'(full >> PainShift);
    end
    res_o = op_q.toward ? ColorW'(c_q + quot) : quot;
  end

endmodule

`default_nettype wire

// ----- src/palette_damage_possession_tint.sv -----
// Palette tint with pain and possession effects. Each transaction on the input
// channel yields exactly one result transaction. Frame end, pain event and set
// possession transactions pass through the S_DONE state and then the output
// register; the input takes the next transaction once the result is presented.
// A tint entry is worked through by one shared multiply-and-divide unit, with
// an S_MUL and an S_DIV state per colour step: 3 steps while pain is active,
// 3 more while possession is active, none if neither is, the result appearing
// in the same cycle as the input is free again. The input stalls while a
// transaction is in progress; a finished result waits in the output register
// while the next transaction is accepted.
`default_nettype none

module palette_damage_possession_tint (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  action_i,
  input  wire logic [pdpt_pkg::ColorW-1:0] red_in_i,
  input  wire logic [pdpt_pkg::ColorW-1:0] green_in_i,
  input  wire logic [pdpt_pkg::ColorW-1:0] blue_in_i,
  input  wire logic [1:0]                  control_mode_i,
  input  wire logic signed [7:0]           pain_amount_i,
  input  wire logic [pdpt_pkg::LevelW-1:0] possession_value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [pdpt_pkg::ColorW-1:0] red_out_o,
  output logic      [pdpt_pkg::ColorW-1:0] green_out_o,
  output logic      [pdpt_pkg::ColorW-1:0] blue_out_o,
  output logic      [pdpt_pkg::LevelW-1:0] frame_level_o
);
  import pdpt_pkg::*;

  state_e              state_q, state_d;
  logic [StepW-1:0]    step_q, step_d;
  logic [ColorW-1:0]   r_q, r_d, g_q, g_d, b_q, b_d;
  logic [LevelW-1:0]   lvl_q, lvl_d;
  logic [LevelW-1:0]   pain_q, pain_d;
  logic [LevelW-1:0]   poss_q, poss_d;
  logic                out_valid_q;
  logic [ColorW-1:0]   red_out_q, green_out_q, blue_out_q;
  logic [LevelW-1:0]   frame_level_q;

  logic                accept;
  logic                issue;
  logic                load_out;
  logic                last_step;
  logic                pain_on, poss_on;
  logic [LevelW-1:0]   poss_min;
  logic [ColorW-1:0]   unit_c;
  logic [LevelW-1:0]   unit_lvl;
  scale_op_t           unit_op;
  logic [ColorW-1:0]   unit_res;
  logic signed [8:0]   pain_sum;
  action_e             action;
  mode_e               mode;

  assign action   = action_e'(action_i);
  assign mode     = mode_e'(control_mode_i);
  assign pain_on  = pain_q != '0;
  assign poss_on  = poss_q != '0;
  assign poss_min = (poss_q > PossDiv) ? PossDiv : poss_q;
  assign accept   = in_valid_i && !in_stall_o;
  assign last_step = (step_q == StepPossBlue) || (step_q == StepPainBlue && !poss_on);
  assign pain_sum = 9'(signed'({5'b0, pain_q})) + 9'(pain_amount_i);

  always_comb begin
    unique case (step_q)
      StepPainRed, StepPossRed:     unit_c = r_q;
      StepPainGreen, StepPossGreen: unit_c = g_q;
      default:                      unit_c = b_q;
    endcase
    unit_lvl       = (step_q < StepPossRed) ? pain_q : poss_min;
    unit_op.toward = (step_q == StepPainRed) || (step_q == StepPossBlue);
    unit_op.div12  = step_q >= StepPossRed;
  end

  pdpt_scale u_scale (
    .clk_i  (clk_i),
    .issue_i(issue),
    .c_i    (unit_c),
    .lvl_i  (unit_lvl),
    .op_i   (unit_op),
    .res_o  (unit_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (action == ACT_TINT && (pain_on || poss_on)) ? S_MUL : S_DONE;
        end
      end
      S_MUL: state_d = S_DIV;
      S_DIV: state_d = last_step ? S_DONE : S_MUL;
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o = state_q != S_IDLE;
    issue      = state_q == S_MUL;
    load_out   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  end

  always_comb begin
    step_d = step_q;
    r_d    = r_q;
    g_d    = g_q;
    b_d    = b_q;
    lvl_d  = lvl_q;
    pain_d = pain_q;
    poss_d = poss_q;
    if (accept) begin
      r_d    = '0;
      g_d    = '0;
      b_d    = '0;
      lvl_d  = '0;
      step_d = pain_on ? StepPainRed : StepPossRed;
      unique case (action)
        ACT_TINT: begin
          r_d = red_in_i;
          g_d = green_in_i;
          b_d = blue_in_i;
        end
        ACT_FRAME: begin
          lvl_d = pain_on ? pain_q : poss_q;
          if (pain_on) begin
            pain_d = pain_q - 1'b1;
          end
          if (poss_on) begin
            unique case (mode)
              MODE_FREEZE: poss_d = poss_q;
              MODE_RAMP_UP: begin
                if (poss_q <= PossDiv) begin
                  poss_d = poss_q + 1'b1;
                end
              end
              default: poss_d = poss_q - 1'b1;
            endcase
          end
        end
        ACT_PAIN: begin
          if (pain_sum < 9'sd1) begin
            pain_d = 4'd1;
          end else if (pain_sum > 9'(PainTop)) begin
            pain_d = PainTop;
          end else begin
            pain_d = LevelW'(pain_sum);
          end
        end
        default: begin
          poss_d = (possession_value_i > PossTop) ? PossTop : possession_value_i;
        end
      endcase
    end else if (state_q == S_DIV) begin
      unique case (step_q)
        StepPainRed, StepPossRed:     r_d = unit_res;
        StepPainGreen, StepPossGreen: g_d = unit_res;
        default:                      b_d = unit_res;
      endcase
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      pain_q      <= '0;
      poss_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      pain_q  <= pain_d;
      poss_q  <= poss_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    g_q   <= g_d;
    b_q   <= b_d;
    lvl_q <= lvl_d;
    if (load_out) begin
      red_out_q     <= r_q;
      green_out_q   <= g_q;
      blue_out_q    <= b_q;
      frame_level_q <= lvl_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_out_o     = red_out_q;
  assign green_out_o   = green_out_q;
  assign blue_out_o    = blue_out_q;
  assign frame_level_o = frame_level_q;

  a_pain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pain_q <= PainTop)
    else $error("pain level out of range");

  a_poss_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    poss_q <= PossTop)
    else $error("possession level out of range");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result presented without finishing");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL || state_q == S_DIV) |-> step_q <= StepPossBlue)
    else $error("colour step out of range");

  a_levels_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL || state_q == S_DIV) |=> $stable(pain_q) && $stable(poss_q))
    else $error("levels changed during tint");

endmodule

`default_nettype wire
